FILE: hw/rtl/indexed_list_engine_top_macros.svh
// Assertion macros used by the indexed list engine port checks
`ifndef INDEXED_LIST_ENGINE_TOP_MACROS_SVH
`define INDEXED_LIST_ENGINE_TOP_MACROS_SVH

// same-cycle implication, held off while in reset
`define ILE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("indexed list engine check failed");

// next-cycle implication, held off while in reset
`define ILE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("indexed list engine check failed");

`endif

FILE: hw/rtl/ile_pkg.sv
// Package: shared constants, codes and result type of the indexed list engine
package ile_pkg;

	localparam int DEPTH_DEF    = 256;
	localparam int KEY_BITS_DEF = 32;

	localparam int OP_W     = 3;
	localparam int KEY_W    = 32;
	localparam int POS_W    = 9;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd2;
	localparam logic [OP_W-1:0] OP_READ   = 3'd3;
	localparam logic [OP_W-1:0] OP_FIND   = 3'd4;
	localparam logic [OP_W-1:0] OP_SORT   = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]    value;
		logic [POS_W-1:0]    where;
		logic                found;
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    count;
	} res_t;

endpackage

FILE: hw/rtl/indexed_list_engine_top.sv
// Top level of the indexed list engine: config register, sequencer, store, result register
//
// The engine keeps an ordered list of up to DEPTH keys of KEY_BITS bits in
// one synchronous memory (one write and one read port, registered read
// data) and a length counter. One request item is taken at a time; each
// runs as a string of read-modify-write steps on that memory, and the
// next item is not taken until the last one is through. Writes, the
// out-of-range and full cases, appends and unused codes finish without
// walking the memory; a read waits for its read data; insert and remove
// shift the tail of the list past the position one place, one entry at a
// time; find is a binary search; sort is an insertion sort, slowest on
// reversed input. Every entry moved or compared costs one read on the
// single memory read port. A finished result sits in an output register,
// so the next item is accepted while it waits. The user must write the
// compare mode register (cfg) only while the engine is idle; the block
// itself does not enforce this. cfg_ready is always high. Store contents
// are not cleared at reset; only the length is, so no clearing pass is needed.
module indexed_list_engine_top #(
	parameter int DEPTH    = ile_pkg::DEPTH_DEF,
	parameter int KEY_BITS = ile_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ile_pkg::OP_W-1:0]      op,
	input  logic [ile_pkg::KEY_W-1:0]     key,
	input  logic [ile_pkg::POS_W-1:0]     position,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ile_pkg::KEY_W-1:0]     value,
	output logic [ile_pkg::POS_W-1:0]     where,
	output logic                          found,
	output logic [ile_pkg::STATUS_W-1:0]  status,
	output logic [ile_pkg::POS_W-1:0]     count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          cmp_signed_q;
	logic          res_valid, res_ready;
	ile_pkg::res_t res;
	logic          out_valid_q;
	ile_pkg::res_t out_q;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [KEY_BITS-1:0] mem_wdata, mem_rdata;

	// compare mode: 0 unsigned, 1 two's complement
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_signed_q <= 1'b0;
		end else if (cfg_valid) begin
			cmp_signed_q <= cfg_data;
		end
	end

	ile_ctrl #(
		.DEPTH (DEPTH),
		.KW    (KEY_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmp_signed (cmp_signed_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.key        (key),
		.position   (position),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	ile_mem #(
		.DEPTH (DEPTH),
		.KW    (KEY_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: the sequencer hands over once the slot is free
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = out_q.value;
	assign where     = out_q.where;
	assign found     = out_q.found;
	assign status    = out_q.status;
	assign count     = out_q.count;

endmodule

FILE: hw/rtl/ile_mem.sv
// Entry store: one write port, one read port, registered read data
module ile_mem #(
	parameter int DEPTH = ile_pkg::DEPTH_DEF,
	parameter int KW    = ile_pkg::KEY_BITS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [KW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [KW-1:0] rdata
);

	logic [KW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/ile_ctrl.sv
// Sequencer: runs each request as read-modify-write steps on the entry store
module ile_ctrl #(
	parameter int DEPTH = ile_pkg::DEPTH_DEF,
	parameter int KW    = ile_pkg::KEY_BITS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int LW   = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmp_signed,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ile_pkg::OP_W-1:0]    op,
	input  logic [ile_pkg::KEY_W-1:0]   key,
	input  logic [ile_pkg::POS_W-1:0]   position,
	output logic                        res_valid,
	input  logic                        res_ready,
	output ile_pkg::res_t               res,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [KW-1:0]               mem_wdata,
	output logic [AW-1:0]               mem_raddr,
	input  logic [KW-1:0]               mem_rdata
);

	localparam int CW = (LW > ile_pkg::POS_W) ? LW : ile_pkg::POS_W;
	localparam int SW = LW + 1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SHU    = 4'd1;
	localparam logic [3:0] S_INSKEY = 4'd2;
	localparam logic [3:0] S_RMV    = 4'd3;
	localparam logic [3:0] S_SHD    = 4'd4;
	localparam logic [3:0] S_RDW    = 4'd5;
	localparam logic [3:0] S_FCHK   = 4'd6;
	localparam logic [3:0] S_FCMP   = 4'd7;
	localparam logic [3:0] S_SK     = 4'd8;
	localparam logic [3:0] S_SKW    = 4'd9;
	localparam logic [3:0] S_SJ     = 4'd10;
	localparam logic [3:0] S_SC     = 4'd11;
	localparam logic [3:0] S_DONE   = 4'd12;

	logic [3:0]    state_q, state_d;
	logic [LW-1:0] len_q, len_d;
	logic [AW-1:0] cur_q, cur_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [LW-1:0] lo_q, lo_d, hip_q, hip_d;
	logic [AW-1:0] mid_q, mid_d;
	logic [AW-1:0] i_q, i_d, j_q, j_d;
	logic [KW-1:0] key_q, key_d;
	ile_pkg::res_t res_q, res_d;

	logic [63:0]   key_wide, rd_wide;
	logic [KW-1:0] key_k, sgn, rd_x, key_x;
	logic          rd_lt_key, key_lt_rd;
	logic [CW-1:0] pos_c, len_c;
	logic [SW-1:0] mid_sum;
	logic [LW-1:0] i_next;

	assign key_wide  = {32'b0, key};
	assign key_k     = key_wide[KW-1:0];
	assign rd_wide   = 64'(mem_rdata);
	assign sgn       = {cmp_signed, {(KW-1){1'b0}}};
	assign rd_x      = mem_rdata ^ sgn;
	assign key_x     = key_q ^ sgn;
	assign rd_lt_key = rd_x < key_x;
	assign key_lt_rd = key_x < rd_x;
	assign pos_c     = CW'(position);
	assign len_c     = CW'(len_q);
	assign mid_sum   = (SW'(lo_q) + SW'(hip_q) - SW'(1)) >> 1;
	assign i_next    = LW'(i_q) + LW'(1);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	// count follows the settled length, which is final once in the done state
	always_comb begin
		res       = res_q;
		res.count = ile_pkg::POS_W'(len_q);
	end

	always_comb begin
		state_d   = state_q;
		len_d     = len_q;
		cur_d     = cur_q;
		pos_d     = pos_q;
		lo_d      = lo_q;
		hip_d     = hip_q;
		mid_d     = mid_q;
		i_d       = i_q;
		j_d       = j_q;
		key_d     = key_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = key_q;
		mem_raddr = cur_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					res_d   = '0;
					key_d   = key_k;
					pos_d   = AW'(position);
					state_d = S_DONE;
					unique case (op)
						ile_pkg::OP_INSERT: begin
							if (pos_c > len_c) begin
								res_d.status = ile_pkg::ST_RANGE;
							end else if (len_q == LW'(DEPTH)) begin
								res_d.status = ile_pkg::ST_FULL;
							end else if (pos_c == len_c) begin
								mem_we    = 1'b1;
								mem_waddr = AW'(position);
								mem_wdata = key_k;
								len_d     = len_q + LW'(1);
							end else begin
								mem_raddr = AW'(len_q - LW'(1));
								cur_d     = AW'(len_q - LW'(1));
								state_d   = S_SHU;
							end
						end
						ile_pkg::OP_REMOVE: begin
							if (pos_c >= len_c) begin
								res_d.status = ile_pkg::ST_RANGE;
							end else begin
								mem_raddr = AW'(position);
								state_d   = S_RMV;
							end
						end
						ile_pkg::OP_WRITE: begin
							if (pos_c >= len_c) begin
								res_d.status = ile_pkg::ST_RANGE;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(position);
								mem_wdata = key_k;
							end
						end
						ile_pkg::OP_READ: begin
							if (pos_c >= len_c) begin
								res_d.status = ile_pkg::ST_RANGE;
							end else begin
								mem_raddr = AW'(position);
								state_d   = S_RDW;
							end
						end
						ile_pkg::OP_FIND: begin
							lo_d    = '0;
							hip_d   = len_q;
							state_d = S_FCHK;
						end
						ile_pkg::OP_SORT: begin
							if (len_q > LW'(1)) begin
								i_d     = AW'(1);
								state_d = S_SK;
							end
						end
						default: ;
					endcase
				end
			end
			S_SHU: begin
				// entry cur moves up one place
				mem_we    = 1'b1;
				mem_waddr = cur_q + AW'(1);
				mem_wdata = mem_rdata;
				if (cur_q == pos_q) begin
					state_d = S_INSKEY;
				end else begin
					mem_raddr = cur_q - AW'(1);
					cur_d     = cur_q - AW'(1);
				end
			end
			S_INSKEY: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = key_q;
				len_d     = len_q + LW'(1);
				state_d   = S_DONE;
			end
			S_RMV: begin
				res_d.value = rd_wide[31:0];
				if (LW'(pos_q) + LW'(1) >= len_q) begin
					len_d   = len_q - LW'(1);
					state_d = S_DONE;
				end else begin
					mem_raddr = pos_q + AW'(1);
					cur_d     = pos_q + AW'(1);
					state_d   = S_SHD;
				end
			end
			S_SHD: begin
				// entry cur moves down one place
				mem_we    = 1'b1;
				mem_waddr = cur_q - AW'(1);
				mem_wdata = mem_rdata;
				if (LW'(cur_q) + LW'(1) == len_q) begin
					len_d   = len_q - LW'(1);
					state_d = S_DONE;
				end else begin
					mem_raddr = cur_q + AW'(1);
					cur_d     = cur_q + AW'(1);
				end
			end
			S_RDW: begin
				res_d.value = rd_wide[31:0];
				state_d     = S_DONE;
			end
			S_FCHK: begin
				if (lo_q < hip_q) begin
					mem_raddr = AW'(mid_sum);
					mid_d     = AW'(mid_sum);
					state_d   = S_FCMP;
				end else begin
					res_d.where = ile_pkg::POS_W'(hip_q);
					state_d     = S_DONE;
				end
			end
			S_FCMP: begin
				if (!rd_lt_key && !key_lt_rd) begin
					res_d.value = rd_wide[31:0];
					res_d.where = ile_pkg::POS_W'(mid_q);
					res_d.found = 1'b1;
					state_d     = S_DONE;
				end else begin
					if (rd_lt_key) begin
						lo_d = LW'(mid_q) + LW'(1);
					end else begin
						hip_d = LW'(mid_q);
					end
					state_d = S_FCHK;
				end
			end
			S_SK: begin
				mem_raddr = i_q;
				state_d   = S_SKW;
			end
			S_SKW: begin
				key_d   = mem_rdata;
				j_d     = i_q;
				state_d = S_SJ;
			end
			S_SJ: begin
				if (j_q == '0) begin
					mem_we    = 1'b1;
					mem_waddr = j_q;
					mem_wdata = key_q;
					i_d       = AW'(i_next);
					state_d   = (i_next < len_q) ? S_SK : S_DONE;
				end else begin
					mem_raddr = j_q - AW'(1);
					state_d   = S_SC;
				end
			end
			S_SC: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				if (key_lt_rd) begin
					mem_wdata = mem_rdata;
					j_d       = j_q - AW'(1);
					state_d   = S_SJ;
				end else begin
					mem_wdata = key_q;
					i_d       = AW'(i_next);
					state_d   = (i_next < len_q) ? S_SK : S_DONE;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		pos_q <= pos_d;
		lo_q  <= lo_d;
		hip_q <= hip_d;
		mid_q <= mid_d;
		i_q   <= i_d;
		j_q   <= j_d;
		key_q <= key_d;
		res_q <= res_d;
	end

endmodule

FILE: hw/rtl/ile_checker.sv
// Port-level checks of the indexed list engine, bound to the top level
`include "indexed_list_engine_top_macros.svh"

module ile_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ile_pkg::KEY_W-1:0]     value,
	input logic                          found,
	input logic [ile_pkg::STATUS_W-1:0]  status
);

	// a waiting result holds
	`ILE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value))
	// only defined status codes reach the port
	`ILE_ASSERT_IMP(a_status_code, out_valid, status == ile_pkg::ST_OK || status == ile_pkg::ST_RANGE || status == ile_pkg::ST_FULL)
	// a flagged request returns no key
	`ILE_ASSERT_IMP(a_err_quiet, out_valid && status != ile_pkg::ST_OK, value == '0 && !found)

endmodule

bind indexed_list_engine_top ile_checker u_ile_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value     (value),
	.found     (found),
	.status    (status)
);

FILE: tb/indexed_list_engine_checker.sv
// Checker for the indexed list engine: predicts each result and compares it
`timescale 1ns / 1ps

module indexed_list_engine_checker
	import ile_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic                cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [OP_W-1:0]     op,
	input  logic [KEY_W-1:0]    key,
	input  logic [POS_W-1:0]    position,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [KEY_W-1:0]    value,
	input  logic [POS_W-1:0]    where,
	input  logic                found,
	input  logic [STATUS_W-1:0] status,
	input  logic [POS_W-1:0]    count,
	output int                  fails,
	output int                  outstanding,
	output int                  results
);

	localparam int LIST_MAX = DEPTH_DEF;

	logic [KEY_W-1:0] list_keys [LIST_MAX];
	int               list_len;
	logic             signed_order;
	res_t             pending_results [$];

	assign outstanding = pending_results.size();

	// ordering under the current compare mode
	function automatic logic key_before(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
		logic [KEY_W-1:0] flip;
		flip = signed_order ? {1'b1, {(KEY_W-1){1'b0}}} : '0;
		return (a ^ flip) < (b ^ flip);
	endfunction

	task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
		$display("%0t mismatch on %s: expected %0h, got %0h", $time, what, exp_v, got_v);
		fails++;
	endtask

	task automatic apply_request(input logic [OP_W-1:0] req_op, input logic [KEY_W-1:0] req_key,
			input int pos, output res_t r);
		int lo, hi, mid, i, j;
		logic hit;
		logic [KEY_W-1:0] k;
		r = '0;
		case (req_op)
			OP_INSERT: begin
				if (pos > list_len) r.status = ST_RANGE;
				else if (list_len >= LIST_MAX) r.status = ST_FULL;
				else begin
					for (i = list_len; i > pos; i--) list_keys[i] = list_keys[i-1];
					list_keys[pos] = req_key;
					list_len++;
				end
			end
			OP_REMOVE: begin
				if (pos >= list_len) r.status = ST_RANGE;
				else begin
					r.value = list_keys[pos];
					for (i = pos; i + 1 < list_len; i++) list_keys[i] = list_keys[i+1];
					list_len--;
				end
			end
			OP_WRITE: begin
				if (pos >= list_len) r.status = ST_RANGE;
				else list_keys[pos] = req_key;
			end
			OP_READ: begin
				if (pos >= list_len) r.status = ST_RANGE;
				else r.value = list_keys[pos];
			end
			OP_FIND: begin
				lo = 0;
				hi = list_len - 1;
				hit = 1'b0;
				while (lo <= hi && !hit) begin
					mid = (lo + hi) / 2;
					if (list_keys[mid] == req_key) begin
						hit = 1'b1;
						r.value = list_keys[mid];
						r.where = mid[POS_W-1:0];
						r.found = 1'b1;
					end else if (key_before(list_keys[mid], req_key)) lo = mid + 1;
					else hi = mid - 1;
				end
				if (!hit) r.where = POS_W'(hi + 1);
			end
			OP_SORT: begin
				for (i = 1; i < list_len; i++) begin
					k = list_keys[i];
					j = i;
					while (j > 0 && key_before(k, list_keys[j-1])) begin
						list_keys[j] = list_keys[j-1];
						j--;
					end
					list_keys[j] = k;
				end
			end
			default: ;
		endcase
		r.count = POS_W'(list_len);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		res_t new_r;
		if (!arst_n) begin
			list_len = 0;
			signed_order = 1'b0;
			pending_results.delete();
			fails = 0;
			results = 0;
		end else begin
			if (cfg_valid && cfg_ready) signed_order = cfg_data;
			if (out_valid && out_ready) begin
				results++;
				if (pending_results.size() == 0) begin
					$display("%0t result with no request waiting", $time);
					fails++;
				end else begin
					exp_r = pending_results.pop_front();
					if (value !== exp_r.value) report("value", exp_r.value, value);
					if (where !== exp_r.where) report("where", 32'(exp_r.where), 32'(where));
					if (found !== exp_r.found) report("found", 32'(exp_r.found), 32'(found));
					if (status !== exp_r.status)
						report("status", 32'(exp_r.status), 32'(status));
					if (count !== exp_r.count) report("count", 32'(exp_r.count), 32'(count));
				end
			end
			if (in_valid && in_ready) begin
				apply_request(op, key, int'(position), new_r);
				pending_results.push_back(new_r);
			end
		end
	end

endmodule

FILE: tb/testbench.sv
// Testbench top: request stimulus, receiver stalls and the verdict
`timescale 1ns / 1ps

module testbench;
	import ile_pkg::*;

	localparam int  LIST_MAX    = DEPTH_DEF;
	localparam int  RANDOM_ITEMS = 680;
	// sorting a full reversed list is the longest single request; the rest are far shorter
	localparam int  CYCLE_LIMIT = 4_000_000;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid, cfg_ready, cfg_data;
	logic                in_valid, in_ready;
	logic [OP_W-1:0]     op;
	logic [KEY_W-1:0]    key;
	logic [POS_W-1:0]    position;
	logic                out_valid, out_ready;
	logic [KEY_W-1:0]    value;
	logic [POS_W-1:0]    where;
	logic                found;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    count;

	int fails, outstanding, results;
	int cycles;
	int sent;
	int list_len;      // length as the sender sees it, for choosing positions
	int burst_left;
	int stall_mode;    // receiver behaviour, changed per phase
	int stall_phase;

	indexed_list_engine_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.key       (key),
		.position  (position),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.where     (where),
		.found     (found),
		.status    (status),
		.count     (count)
	);

	indexed_list_engine_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.key         (key),
		.position    (position),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.where       (where),
		.found       (found),
		.status      (status),
		.count       (count),
		.fails       (fails),
		.outstanding (outstanding),
		.results     (results)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: 0 always ready, 1 mostly ready, 2 mostly stalled, 3 fixed 5-of-8 pattern
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((stall_phase % 8) < 5);
		endcase
	end

	// one request item; valid stays high across a burst, gaps fall between bursts
	task automatic send(input logic [OP_W-1:0] o, input logic [KEY_W-1:0] k, input int p);
		int gap;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		op       <= o;
		key      <= k;
		position <= POS_W'(p);
		do @(posedge clk); while (!in_ready);
		sent++;
		if (o == OP_INSERT && p <= list_len && list_len < LIST_MAX) list_len++;
		if (o == OP_REMOVE && p < list_len) list_len--;
	endtask

	// compare mode changes only once the engine has gone quiet
	task automatic set_order(input logic signed_keys);
		in_valid <= 1'b0;
		burst_left = 0;
		// let the checker log the last accepted item first
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= signed_keys;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		stall_mode <= $urandom_range(0, 3);
	endtask

	// keys that hit the ordering corners, so finds often land
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4, 5: return KEY_W'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	task automatic random_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30 && list_len < 60) send(OP_INSERT, pick_key(), $urandom_range(0, list_len));
		else if (r < 48 && list_len > 0) send(OP_REMOVE, '0, $urandom_range(0, list_len - 1));
		else if (r < 60 && list_len > 0) send(OP_WRITE, pick_key(), $urandom_range(0, list_len - 1));
		else if (r < 72 && list_len > 0) send(OP_READ, $urandom, $urandom_range(0, list_len - 1));
		else if (r < 88) send(OP_FIND, pick_key(), $urandom_range(0, 511));
		else if (r < 93) send(OP_SORT, $urandom, $urandom_range(0, 511));
		// malformed: a position past the end, or an unused op code
		else if (r < 97) send(OP_W'($urandom_range(0, 3)), $urandom, $urandom_range(list_len + 1, 511));
		else send(OP_W'($urandom_range(6, 7)), $urandom, $urandom_range(0, 511));
	endtask

	initial begin
		int i;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = 1'b0;
		in_valid    = 1'b0;
		op          = OP_INSERT;
		key         = '0;
		position    = '0;
		stall_mode  = 0;
		sent        = 0;
		list_len    = 0;
		burst_left  = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, extremes, bad positions, unused codes
		set_order(1'b0);
		send(OP_FIND, 32'h1234, 0);
		send(OP_SORT, '0, 0);
		send(OP_READ, '0, 0);
		send(OP_REMOVE, '0, 0);
		send(OP_WRITE, 32'hDEAD_BEEF, 0);
		send(OP_INSERT, 32'h5, 1);
		send(OP_INSERT, 32'hFFFF_FFFF, 0);
		send(OP_INSERT, 32'h0000_0000, 0);
		send(OP_INSERT, 32'h8000_0000, 1);
		send(OP_INSERT, 32'h7FFF_FFFF, 3);
		send(OP_READ, '0, 3);
		send(OP_WRITE, 32'h7FFF_FFFE, 2);
		send(OP_READ, '0, 4);
		send(OP_FIND, 32'hFFFF_FFFF, 0);
		send(OP_SORT, '0, 511);
		send(OP_FIND, 32'h8000_0000, 0);
		send(OP_FIND, 32'h4000_0000, 0);
		send(3'd6, 32'hFFFF_FFFF, 511);
		send(3'd7, '0, 256);
		set_order(1'b1);
		send(OP_SORT, '0, 0);
		send(OP_FIND, 32'h8000_0000, 0);
		send(OP_FIND, 32'hFFFF_FFFF, 0);
		send(OP_REMOVE, '0, 3);
		send(OP_REMOVE, '0, 0);

		// fill to capacity, hit the full case and range on a full list, sort it, drain most
		while (list_len < LIST_MAX) send(OP_INSERT, $urandom, $urandom_range(0, list_len));
		send(OP_INSERT, 32'h1, 0);
		send(OP_INSERT, 32'h1, 257);
		send(OP_READ, '0, 256);
		send(OP_READ, '0, 255);
		send(OP_SORT, '0, 0);
		for (i = 0; i < 8; i++) send(OP_FIND, $urandom, 0);
		while (list_len > 20) send(OP_REMOVE, '0, list_len - 1);

		// random phases over both compare modes
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 275 == 0) set_order(((i / 275) % 2) == 0);
			random_request();
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Ran %0d requests and checked %0d results in both compare modes,", sent, results);
		$display("including empty and full lists, bad positions and unused op codes.");
		if (fails == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ile_pkg.sv
hw/rtl/ile_mem.sv
hw/rtl/ile_ctrl.sv
hw/rtl/indexed_list_engine_top.sv
hw/rtl/ile_checker.sv
tb/indexed_list_engine_checker.sv
tb/testbench.sv
